FILE: src/mnp_frame_receiver_crc16_unit_macros.svh
// Assertion helpers shared by the receiver RTL.
`ifndef MNP_FRAME_RECEIVER_CRC16_UNIT_MACROS_SVH
`define MNP_FRAME_RECEIVER_CRC16_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfr assertion failed");

// Next-cycle implication, disabled during reset.
`define MFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfr assertion failed");

`endif

FILE: src/mfr_pkg.sv
// ----------------------------------------------------------------------------
// mfr_pkg
// Types and constants for the DLE framed CRC-16 frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfr_pkg;

  localparam int MaxFrameDefault = 512;

  localparam logic [7:0]  SyncByte   = 8'h16;
  localparam logic [7:0]  DleByte    = 8'h10;
  localparam logic [7:0]  StxByte    = 8'h02;
  localparam logic [7:0]  EtxByte    = 8'h03;
  localparam logic [15:0] CrcPoly    = 16'hA001;
  localparam logic [9:0]  MaxLenInit = 10'd512;

  typedef enum logic [6:0] {
    PH_HUNT1 = 7'b0000001,
    PH_HUNT2 = 7'b0000010,
    PH_HUNT3 = 7'b0000100,
    PH_BODY  = 7'b0001000,
    PH_ESC   = 7'b0010000,
    PH_FCSLO = 7'b0100000,
    PH_FCSHI = 7'b1000000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_BODY = 3'd0,
    KIND_GOOD = 3'd1,
    KIND_FCS  = 3'd2,
    KIND_ESC  = 3'd3,
    KIND_LONG = 3'd4
  } kind_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic [8:0] index;
    logic [9:0] length;
    logic [7:0] ftype;
  } result_t;

endpackage

FILE: src/mfr_crc16.sv
// ----------------------------------------------------------------------------
// mfr_crc16
// One-byte update of the reflected CRC-16, LSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_crc16 (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    logic [7:0]  b;
    c = crc_i;
    b = data_i;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[0]) begin
        c = (c >> 1) ^ mfr_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    crc_o = c;
  end

endmodule

FILE: src/mfr_fsm.sv
// ----------------------------------------------------------------------------
// mfr_fsm
// Frame state: start hunt, DLE unstuffing, body count, CRC and FCS check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_fsm #(
  parameter int MAX_FRAME = mfr_pkg::MaxFrameDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        data_i,
  input  logic [9:0]        max_len_i,
  output mfr_pkg::result_t  res_o
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int LW = (CW > 10) ? CW : 10;

  mfr_pkg::phase_e phase_q, phase_d;
  logic [15:0]     crc_q, crc_d, crc_next;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [7:0]      type_q, type_d;

  logic [LW-1:0]   limit, ml_ext, mf_ext, cnt_ext, cnt_d_ext;
  logic            take_body;

  mfr_crc16 u_crc (
    .crc_i  (crc_q),
    .data_i (data_i),
    .crc_o  (crc_next)
  );

  assign ml_ext    = LW'(max_len_i);
  assign mf_ext    = LW'(MAX_FRAME);
  assign limit     = (ml_ext > mf_ext) ? mf_ext : ml_ext;
  assign cnt_ext   = LW'(cnt_q);
  assign cnt_d_ext = LW'(cnt_d);

  always_comb begin
    phase_d   = phase_q;
    crc_d     = crc_q;
    cnt_d     = cnt_q;
    type_d    = type_q;
    take_body = 1'b0;
    res_o     = '0;
    res_o.kind = mfr_pkg::KIND_BODY;

    case (phase_q)
      mfr_pkg::PH_HUNT1: begin
        if (data_i == mfr_pkg::SyncByte) phase_d = mfr_pkg::PH_HUNT2;
      end
      mfr_pkg::PH_HUNT2: begin
        phase_d = (data_i == mfr_pkg::DleByte) ? mfr_pkg::PH_HUNT3 : mfr_pkg::PH_HUNT1;
      end
      mfr_pkg::PH_HUNT3: begin
        if (data_i == mfr_pkg::StxByte) begin
          phase_d = mfr_pkg::PH_BODY;
          crc_d   = '0;
          cnt_d   = '0;
          type_d  = '0;
        end else begin
          phase_d = mfr_pkg::PH_HUNT1;
        end
      end
      mfr_pkg::PH_BODY: begin
        if (data_i == mfr_pkg::DleByte) phase_d = mfr_pkg::PH_ESC;
        else take_body = 1'b1;
      end
      mfr_pkg::PH_ESC: begin
        if (data_i == mfr_pkg::DleByte) begin
          take_body = 1'b1;
        end else if (data_i == mfr_pkg::EtxByte) begin
          crc_d   = crc_next;
          phase_d = mfr_pkg::PH_FCSLO;
        end else begin
          phase_d    = mfr_pkg::PH_HUNT1;
          res_o.valid = 1'b1;
          res_o.kind  = mfr_pkg::KIND_ESC;
        end
      end
      mfr_pkg::PH_FCSLO: begin
        if (crc_q[7:0] != data_i) begin
          phase_d     = mfr_pkg::PH_HUNT1;
          res_o.valid = 1'b1;
          res_o.kind  = mfr_pkg::KIND_FCS;
        end else begin
          phase_d = mfr_pkg::PH_FCSHI;
        end
      end
      mfr_pkg::PH_FCSHI: begin
        phase_d     = mfr_pkg::PH_HUNT1;
        res_o.valid = 1'b1;
        res_o.kind  = (crc_q[15:8] != data_i) ? mfr_pkg::KIND_FCS : mfr_pkg::KIND_GOOD;
      end
      default: begin
        phase_d = mfr_pkg::PH_HUNT1;
      end
    endcase

    if (take_body) begin
      crc_d       = crc_next;
      res_o.valid = 1'b1;
      if (cnt_ext >= limit) begin
        // over the limit: byte dropped, frame aborted
        phase_d    = mfr_pkg::PH_HUNT1;
        res_o.kind = mfr_pkg::KIND_LONG;
      end else begin
        if (cnt_q == CW'(1)) type_d = data_i;
        cnt_d       = cnt_q + CW'(1);
        phase_d     = mfr_pkg::PH_BODY;
        res_o.data  = data_i;
        res_o.index = cnt_ext[8:0];
      end
    end

    res_o.length = cnt_d_ext[9:0];
    res_o.ftype  = type_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mfr_pkg::PH_HUNT1;
      crc_q   <= '0;
      cnt_q   <= '0;
      type_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
      type_q  <= type_d;
    end
  end

endmodule

FILE: src/mnp_frame_receiver_crc16_unit.sv
// A byte in the input register passes through the frame logic to the result register
//   when the input register advances; its result (if any) is visible once loaded.
// Throughput: one byte per cycle; the input register advances whenever the
//   result register is empty or its transfer completes in that cycle.
// Reset: asynchronous, active low; hunt restarts, CRC/count/type clear,
//   max_length returns to 512, both registers empty.
// ----------------------------------------------------------------------------
// mnp_frame_receiver_crc16_unit
// DLE framed serial receiver with CRC-16 frame check, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mnp_frame_receiver_crc16_unit_macros.svh"

module mnp_frame_receiver_crc16_unit #(
  parameter int MAX_FRAME = mfr_pkg::MaxFrameDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [8:0] out_index_o,
  output logic [9:0] frame_length_o,
  output logic [7:0] frame_type_o
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic [9:0]       max_len_q;
  logic             adv;
  mfr_pkg::result_t res;

  logic             out_valid_q;
  logic [2:0]       out_kind_q;
  logic [7:0]       out_byte_q;
  logic [8:0]       out_index_q;
  logic [9:0]       out_len_q;
  logic [7:0]       out_type_q;

  // input register moves on when the result slot is free or being taken
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mfr_pkg::MaxLenInit;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_byte_q <= rx_byte_i;
  end

  mfr_fsm #(
    .MAX_FRAME (MAX_FRAME)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .data_i    (in_byte_q),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res.valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_kind_q  <= res.kind;
      out_byte_q  <= res.data;
      out_index_q <= res.index;
      out_len_q   <= res.length;
      out_type_q  <= res.ftype;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_byte_o     = out_byte_q;
  assign out_index_o    = out_index_q;
  assign frame_length_o = out_len_q;
  assign frame_type_o   = out_type_q;

  `MFR_ASSERT_NOW(a_body_len, clk_i, rst_ni,
    out_valid_o && (out_kind_o == mfr_pkg::KIND_BODY),
    frame_length_o[8:0] == (out_index_o + 9'd1))
  `MFR_ASSERT_NOW(a_end_zero, clk_i, rst_ni,
    out_valid_o && (out_kind_o != mfr_pkg::KIND_BODY),
    (out_byte_o == 8'd0) && (out_index_o == 9'd0))
  `MFR_ASSERT_NEXT(a_in_load, clk_i, rst_ni,
    !in_stall_o,
    in_valid_q == $past(in_valid_i))

endmodule

FILE: verif/mnp_frame_receiver_crc16_unit_test.sv
// ----------------------------------------------------------------------------
// mnp_frame_receiver_crc16_unit_test
// Self-checking bench for the DLE framed CRC-16 receiver. A short table of
// frames covers the start hunt, escapes, end reports and the body byte
// extremes. Random well-formed frames follow, mixed with noise and broken
// tails, under several max_length settings. Each accepted byte runs through
// a behavioral frame decoder, and every result transfer is checked against
// it, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mnp_frame_receiver_crc16_unit_test;
  import mfr_pkg::*;

  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned SettingShare = 45;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [8:0] idx;
    logic [9:0] len;
    logic [7:0] ftype;
  } rx_report_t;

  typedef enum logic [2:0] {
    SRC_RAW, SRC_CRC_LO, SRC_CRC_HI, SRC_CRC_LO_BAD, SRC_CRC_HI_BAD
  } byte_src_e;

  typedef enum logic [1:0] {
    END_GOOD, END_BAD_HI, END_BAD_LO, END_BAD_ESC
  } frame_end_e;

  typedef struct packed {
    byte_src_e  src;
    logic [7:0] value;
    logic       typed;
    rx_report_t want;
  } dir_row_t;

  localparam rx_report_t NoReport = '{KIND_BODY, 8'h00, 9'd0, 10'd0, 8'h00};

  localparam dir_row_t DirectedRows [27] = '{
    // empty body, good FCS
    '{SRC_RAW, SyncByte, 1'b0, NoReport},
    '{SRC_RAW, DleByte, 1'b0, NoReport},
    '{SRC_RAW, StxByte, 1'b0, NoReport},
    '{SRC_RAW, DleByte, 1'b0, NoReport},
    '{SRC_RAW, EtxByte, 1'b0, NoReport},
    '{SRC_CRC_LO, 8'h00, 1'b0, NoReport},
    '{SRC_CRC_HI, 8'h00, 1'b1, '{KIND_GOOD, 8'h00, 9'd0, 10'd0, 8'h00}},
    // second sync byte breaks the hunt and is not retried as a start
    '{SRC_RAW, SyncByte, 1'b0, NoReport},
    '{SRC_RAW, SyncByte, 1'b0, NoReport},
    '{SRC_RAW, DleByte, 1'b0, NoReport},
    '{SRC_RAW, StxByte, 1'b0, NoReport},
    // body extremes, stuffed DLE, then a bad escape
    '{SRC_RAW, SyncByte, 1'b0, NoReport},
    '{SRC_RAW, DleByte, 1'b0, NoReport},
    '{SRC_RAW, StxByte, 1'b0, NoReport},
    '{SRC_RAW, 8'h00, 1'b1, '{KIND_BODY, 8'h00, 9'd0, 10'd1, 8'h00}},
    '{SRC_RAW, 8'hFF, 1'b0, NoReport},
    '{SRC_RAW, DleByte, 1'b0, NoReport},
    '{SRC_RAW, DleByte, 1'b0, NoReport},
    '{SRC_RAW, DleByte, 1'b0, NoReport},
    '{SRC_RAW, 8'h41, 1'b1, '{KIND_ESC, 8'h00, 9'd0, 10'd3, 8'hFF}},
    // low FCS byte wrong: ends at once
    '{SRC_RAW, SyncByte, 1'b0, NoReport},
    '{SRC_RAW, DleByte, 1'b0, NoReport},
    '{SRC_RAW, StxByte, 1'b0, NoReport},
    '{SRC_RAW, 8'h5A, 1'b0, NoReport},
    '{SRC_RAW, DleByte, 1'b0, NoReport},
    '{SRC_RAW, EtxByte, 1'b0, NoReport},
    '{SRC_CRC_LO_BAD, 8'h00, 1'b1, '{KIND_FCS, 8'h00, 9'd0, 10'd1, 8'h00}}
  };

  localparam logic [7:0] BodySpecials [6] = '{DleByte, EtxByte, SyncByte, StxByte,
                                              8'h00, 8'hFF};
  localparam logic [7:0] StartBytes [3] = '{SyncByte, DleByte, StxByte};

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [9:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] out_kind_o;
  logic [7:0] out_byte_o;
  logic [8:0] out_index_o;
  logic [9:0] frame_length_o;
  logic [7:0] frame_type_o;

  // decoder state, mirrors the block
  phase_e      rx_phase = PH_HUNT1;
  logic [15:0] rx_crc = '0;
  logic [9:0]  rx_count = '0;
  logic [7:0]  rx_type = '0;
  logic [9:0]  max_len = MaxLenInit;

  rx_report_t  pending_reports [$];
  int unsigned bytes_sent = 0;
  int unsigned mismatch_count = 0;
  bit          quiet = 1'b0;
  bit          last_step_reported;

  mnp_frame_receiver_crc16_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .out_index_o    (out_index_o),
    .frame_length_o (frame_length_o),
    .frame_type_o   (frame_type_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc,
                                                 input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Advances the decoder by one received byte; returns 1 with the report
  // when the byte produces a result.
  function automatic bit frame_decode(input logic [7:0] b, output rx_report_t rep);
    logic [9:0] lim;
    bit         got;
    bit         is_body;
    got = 1'b0;
    is_body = 1'b0;
    rep = NoReport;
    lim = (max_len > 10'(MaxFrameDefault)) ? 10'(MaxFrameDefault) : max_len;
    case (rx_phase)
      PH_HUNT1: if (b == SyncByte) rx_phase = PH_HUNT2;
      PH_HUNT2: rx_phase = (b == DleByte) ? PH_HUNT3 : PH_HUNT1;
      PH_HUNT3: begin
        if (b == StxByte) begin
          rx_phase = PH_BODY;
          rx_crc = '0;
          rx_count = '0;
          rx_type = '0;
        end else begin
          rx_phase = PH_HUNT1;
        end
      end
      PH_BODY: begin
        if (b == DleByte) begin
          rx_phase = PH_ESC;
        end else begin
          is_body = 1'b1;
        end
      end
      PH_ESC: begin
        if (b == DleByte) begin
          is_body = 1'b1;
        end else if (b == EtxByte) begin
          rx_crc = crc16_arc_byte(rx_crc, b);
          rx_phase = PH_FCSLO;
        end else begin
          rx_phase = PH_HUNT1;
          rep.kind = KIND_ESC;
          got = 1'b1;
        end
      end
      PH_FCSLO: begin
        if (rx_crc[7:0] != b) begin
          rx_phase = PH_HUNT1;
          rep.kind = KIND_FCS;
          got = 1'b1;
        end else begin
          rx_phase = PH_FCSHI;
        end
      end
      PH_FCSHI: begin
        rx_phase = PH_HUNT1;
        rep.kind = (rx_crc[15:8] != b) ? KIND_FCS : KIND_GOOD;
        got = 1'b1;
      end
      default: rx_phase = PH_HUNT1;
    endcase
    if (is_body) begin
      rx_crc = crc16_arc_byte(rx_crc, b);
      got = 1'b1;
      if (rx_count >= lim) begin
        rx_phase = PH_HUNT1;
        rep.kind = KIND_LONG;
      end else begin
        rep.kind = KIND_BODY;
        rep.data = b;
        rep.idx = rx_count[8:0];
        if (rx_count == 10'd1) rx_type = b;
        rx_count = rx_count + 10'd1;
        rx_phase = PH_BODY;
      end
    end
    rep.len = rx_count;
    rep.ftype = rx_type;
    return got;
  endfunction

  function automatic logic [7:0] src_byte(input byte_src_e src, input logic [7:0] raw);
    case (src)
      SRC_CRC_LO:     return rx_crc[7:0];
      SRC_CRC_HI:     return rx_crc[15:8];
      SRC_CRC_LO_BAD: return rx_crc[7:0] ^ 8'($urandom_range(1, 255));
      SRC_CRC_HI_BAD: return rx_crc[15:8] ^ 8'($urandom_range(1, 255));
      default:        return raw;
    endcase
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t %s: expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Caller lowers in_valid_i in the step where the last transfer lands.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    rx_report_t  rep;
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    last_step_reported = frame_decode(b, rep);
    if (last_step_reported) pending_reports.push_back(rep);
    bytes_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input frame_end_e tail);
    logic [7:0] b;
    // finish off a start sequence left half done by noise
    while (rx_phase == PH_HUNT2 || rx_phase == PH_HUNT3) send_byte(8'h00);
    send_byte(SyncByte);
    send_byte(DleByte);
    send_byte(StxByte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(4) == 0) begin
        b = BodySpecials[$urandom_range(5)];
      end else begin
        b = 8'($urandom_range(255));
      end
      if (b == DleByte) send_byte(DleByte);
      send_byte(b);
    end
    send_byte(DleByte);
    if (tail == END_BAD_ESC) begin
      do b = 8'($urandom_range(255)); while (b == DleByte || b == EtxByte);
      send_byte(b);
    end else begin
      send_byte(EtxByte);
      send_byte(src_byte(tail == END_BAD_LO ? SRC_CRC_LO_BAD : SRC_CRC_LO, 8'h00));
      if (tail != END_BAD_LO) begin
        send_byte(src_byte(tail == END_BAD_HI ? SRC_CRC_HI_BAD : SRC_CRC_HI, 8'h00));
      end
    end
  endtask

  task automatic run_setting(input logic [9:0] setting, input bit with_long);
    int unsigned first;
    int unsigned lim;
    int unsigned len;
    int unsigned r;
    frame_end_e  tail;
    // drain, then give the last byte time to clear the pipeline
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= setting;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_len = setting;
    lim = (setting > MaxFrameDefault) ? MaxFrameDefault : setting;
    // one frame past the clamped limit reaches the top index and length
    if (with_long) send_frame(MaxFrameDefault + 1, END_GOOD);
    first = bytes_sent;
    while (bytes_sent - first < SettingShare) begin
      quiet = ($urandom_range(4) == 0);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(1) == 0) send_byte(StartBytes[$urandom_range(2)]);
          else send_byte(8'($urandom_range(255)));
        end
      end
      if (lim <= 20) len = $urandom_range(0, lim + 2);
      else if ($urandom_range(9) == 0) len = $urandom_range(13, 24);
      else len = $urandom_range(0, 12);
      r = $urandom_range(99);
      if (r < 60) tail = END_GOOD;
      else if (r < 72) tail = END_BAD_HI;
      else if (r < 84) tail = END_BAD_LO;
      else tail = END_BAD_ESC;
      send_frame(len, tail);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [9:0] settings [8];
    settings = '{10'd1, 10'd0, 10'd3, 10'd1023, 10'($urandom_range(4, 20)),
                 10'($urandom_range(1, 512)), 10'd2, 10'd512};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (DirectedRows[r]) begin
      send_byte(src_byte(DirectedRows[r].src, DirectedRows[r].value));
      if (DirectedRows[r].typed) begin
        if (last_step_reported) void'(pending_reports.pop_back());
        pending_reports.push_back(DirectedRows[r].want);
      end
    end
    in_valid_i <= 1'b0;
    foreach (settings[s]) run_setting(settings[s], settings[s] == 10'd1023);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("mnp_frame_receiver_crc16_unit_test: done, clean");
    end else begin
      $display("mnp_frame_receiver_crc16_unit_test: done, errors");
    end
    $finish;
  end

  initial begin : result_port
    int unsigned hold;
    int unsigned n;
    rx_report_t  want;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t result transfer: expected none, actual kind %0d byte %0h index %0d",
                   $time, out_kind_o, out_byte_o, out_index_o);
        end else begin
          want = pending_reports.pop_front();
          check_field("out_kind", want.kind, out_kind_o);
          check_field("out_byte", want.data, out_byte_o);
          check_field("out_index", want.idx, out_index_o);
          check_field("frame_length", want.len, frame_length_o);
          check_field("frame_type", want.ftype, frame_type_o);
        end
      end
      if (hold != 0) begin
        hold--;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        hold = idle_len();
      end else begin
        n = idle_len();
        if (n != 0) begin
          out_stall_i <= 1'b1;
          hold = n - 1;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("mnp_frame_receiver_crc16_unit_test: done, errors");
    $finish;
  end

endmodule
